// ===== src/cscf_pkg.sv =====
`timescale 1ns / 1ps

package cscf_pkg;

   localparam int NUM_WEIGHTS     = 5;
   localparam int LEVELS          = 5;
   localparam int COST_BITS       = 16;
   localparam int INPUT_COST_BITS = 16;
   localparam int COST_USED       = (COST_BITS < INPUT_COST_BITS) ? COST_BITS : INPUT_COST_BITS;
   localparam int WEIGHT_BITS     = 17;
   localparam int PRODUCT_BITS    = WEIGHT_BITS + COST_USED;
   localparam int FUSED_BITS      = 35;
   localparam int LEVEL_BITS      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SUM_BITS        = (PRODUCT_BITS + LEVEL_BITS > FUSED_BITS + 1) ?
                                    PRODUCT_BITS + LEVEL_BITS : FUSED_BITS + 1;
   localparam int DISP_BITS       = 8;
   localparam int COUNT_BITS      = 9;
   localparam int SCALE_BITS      = 8;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LEVEL_0  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LEVEL_1  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LEVEL_2  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LEVEL_3  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_LEVEL_4  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DISPARITY   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPARITY_SCALE = 3'd6;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE        = 17'd65536;
   localparam logic [COUNT_BITS-1:0]  MAX_DISP_RESET    = 9'd64;
   localparam logic [COUNT_BITS-1:0]  MAX_DISP_LOW      = 9'd2;
   localparam logic [COUNT_BITS-1:0]  MAX_DISP_HIGH     = 9'd256;
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET       = 8'd1;
   localparam logic [DISP_BITS-1:0]   FIRST_DISPARITY   = 8'd1;

   typedef logic [WEIGHT_BITS-1:0]  weight_type;
   typedef logic [PRODUCT_BITS-1:0] product_type;
   typedef logic [FUSED_BITS-1:0]   fused_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] max_disparity;
      logic [SCALE_BITS-1:0] disparity_scale;
   } cfg_type;

endpackage

// ===== src/cscf_channels.sv =====
`timescale 1ns / 1ps

interface cscf_req_if;
   import cscf_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [INPUT_COST_BITS-1:0] cost_level_0;
   logic [INPUT_COST_BITS-1:0] cost_level_1;
   logic [INPUT_COST_BITS-1:0] cost_level_2;
   logic [INPUT_COST_BITS-1:0] cost_level_3;
   logic [INPUT_COST_BITS-1:0] cost_level_4;

   modport source (output valid, output cost_level_0, output cost_level_1,
                   output cost_level_2, output cost_level_3, output cost_level_4,
                   input ready);
   modport sink (input valid, input cost_level_0, input cost_level_1,
                 input cost_level_2, input cost_level_3, input cost_level_4,
                 output ready);
endinterface

interface cscf_rsp_if;
   import cscf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FUSED_BITS-1:0] fused_cost;
   logic [DISP_BITS-1:0]  disparity;
   logic                  disparity_valid;

   modport source (output valid, output fused_cost, output disparity,
                   output disparity_valid, input ready);
   modport sink (input valid, input fused_cost, input disparity,
                 input disparity_valid, output ready);
endinterface

// ===== src/cross_scale_cost_fusion_wta.sv =====
`timescale 1ns / 1ps

// Cross-scale cost fusion with winner-take-all. Feed one transfer per candidate
// disparity d = 1 .. max_disparity-1 of a pixel, carrying that pixel's matching
// cost from each pyramid level. Every transfer yields one result: the weighted
// sum of the level costs (Q19.16, clamped to all ones) and, on the last candidate
// of the pixel, the earliest minimum-cost disparity times disparity_scale (low
// 8 bits) with disparity_valid set. The block takes one item per cycle while the
// output is not stalled. Each result passes through the per-level multiplier lanes,
// the adder that merges them and the running-minimum stage, whose compare and update
// are combinational ahead of that stage's output registers.
// Backpressure stalls only the stages that are full. Write the configuration
// registers only while no pixel is in flight; the disparity count is clamped
// to the range 2 to 256.
module cross_scale_cost_fusion_wta (
   input  logic                                  clock,
   input  logic                                  reset,
   cscf_req_if.sink                              req_chan,
   cscf_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [cscf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cscf_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import cscf_pkg::*;

   weight_type            weight_ff [NUM_WEIGHTS];
   weight_type            weight_in [NUM_WEIGHTS];
   logic [COUNT_BITS-1:0] max_disp_ff, max_disp_in;
   logic [SCALE_BITS-1:0] scale_ff,    scale_in;
   cfg_type               cfg;

   logic [INPUT_COST_BITS-1:0] costs [NUM_WEIGHTS];
   product_type           products [LEVELS];
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_ready;
   logic                  merge_in_ready;
   logic                  merge_valid;
   fused_type             merge_fused;
   logic                  wta_in_ready;

   // configuration registers
   always_comb begin
      for (int s = 0; s < NUM_WEIGHTS; s++) begin
         weight_in[s] = weight_ff[s];
      end
      max_disp_in = max_disp_ff;
      scale_in    = scale_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WEIGHT_LEVEL_0:  weight_in[0] = csr_write_data[WEIGHT_BITS-1:0];
            CSR_WEIGHT_LEVEL_1:  weight_in[1] = csr_write_data[WEIGHT_BITS-1:0];
            CSR_WEIGHT_LEVEL_2:  weight_in[2] = csr_write_data[WEIGHT_BITS-1:0];
            CSR_WEIGHT_LEVEL_3:  weight_in[3] = csr_write_data[WEIGHT_BITS-1:0];
            CSR_WEIGHT_LEVEL_4:  weight_in[4] = csr_write_data[WEIGHT_BITS-1:0];
            CSR_MAX_DISPARITY:   max_disp_in  = csr_write_data[COUNT_BITS-1:0];
            CSR_DISPARITY_SCALE: scale_in     = csr_write_data[SCALE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[0] <= WEIGHT_ONE;
         for (int s = 1; s < NUM_WEIGHTS; s++) begin
            weight_ff[s] <= '0;
         end
         max_disp_ff <= MAX_DISP_RESET;
         scale_ff    <= SCALE_RESET;
      end else begin
         for (int s = 0; s < NUM_WEIGHTS; s++) begin
            weight_ff[s] <= weight_in[s];
         end
         max_disp_ff <= max_disp_in;
         scale_ff    <= scale_in;
      end
   end

   assign cfg.max_disparity   = max_disp_ff;
   assign cfg.disparity_scale = scale_ff;

   // multiplier lanes
   assign costs[0] = req_chan.cost_level_0;
   assign costs[1] = req_chan.cost_level_1;
   assign costs[2] = req_chan.cost_level_2;
   assign costs[3] = req_chan.cost_level_3;
   assign costs[4] = req_chan.cost_level_4;

   assign s1_ready       = !s1_valid_ff || merge_in_ready;
   assign s1_valid_in    = s1_ready ? req_chan.valid : s1_valid_ff;
   assign req_chan.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   for (genvar s = 0; s < LEVELS; s++) begin : g_lane
      cscf_lane u_lane (
         .clock   (clock),
         .enable  (s1_ready),
         .weight  (weight_ff[s]),
         .cost    (costs[s][COST_USED-1:0]),
         .product (products[s])
      );
   end

   cscf_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (merge_in_ready),
      .products  (products),
      .out_valid (merge_valid),
      .out_ready (wta_in_ready),
      .fused     (merge_fused)
   );

   cscf_wta u_wta (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (merge_valid),
      .in_ready      (wta_in_ready),
      .fused         (merge_fused),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_fused     (rsp_chan.fused_cost),
      .out_disparity (rsp_chan.disparity),
      .out_last      (rsp_chan.disparity_valid)
   );

   a_disp_zero_unless_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.disparity_valid |-> rsp_chan.disparity == '0)
      else $error("disparity nonzero on a non-final candidate");

   a_lane_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !merge_in_ready |=> s1_valid_ff)
      else $error("lane stage dropped an item while stalled");

   a_accept_fills_lanes: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_valid_ff)
      else $error("accepted item did not reach the lane stage");

endmodule

// ===== src/cscf_lane.sv =====
`timescale 1ns / 1ps

module cscf_lane (
   input  logic                   clock,
   input  logic                   enable,
   input  cscf_pkg::weight_type   weight,
   input  logic [cscf_pkg::COST_USED-1:0] cost,
   output cscf_pkg::product_type  product
);
   import cscf_pkg::*;

   product_type product_ff;
   product_type product_in;

   assign product_in = PRODUCT_BITS'(weight) * PRODUCT_BITS'(cost);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

endmodule

// ===== src/cscf_merge.sv =====
`timescale 1ns / 1ps

module cscf_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cscf_pkg::product_type products [cscf_pkg::LEVELS],
   output logic                  out_valid,
   input  logic                  out_ready,
   output cscf_pkg::fused_type   fused
);
   import cscf_pkg::*;

   localparam logic [SUM_BITS-1:0] FUSED_MAX = SUM_BITS'({FUSED_BITS{1'b1}});

   logic                valid_ff;
   logic                valid_in;
   fused_type           fused_ff;
   fused_type           fused_in;
   logic [SUM_BITS-1:0] sum_raw;

   always_comb begin
      sum_raw = '0;
      for (int s = 0; s < LEVELS; s++) begin
         sum_raw = sum_raw + SUM_BITS'(products[s]);
      end
      // clamp anything past the output width
      if (sum_raw > FUSED_MAX) begin
         fused_in = '1;
      end else begin
         fused_in = sum_raw[FUSED_BITS-1:0];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign fused     = fused_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         fused_ff <= fused_in;
      end
   end

endmodule

// ===== src/cscf_wta.sv =====
`timescale 1ns / 1ps

module cscf_wta (
   input  logic                 clock,
   input  logic                 reset,
   input  cscf_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cscf_pkg::fused_type  fused,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cscf_pkg::fused_type  out_fused,
   output logic [cscf_pkg::DISP_BITS-1:0] out_disparity,
   output logic                 out_last
);
   import cscf_pkg::*;

   logic                  take;
   logic                  better;
   logic                  last;
   logic [COUNT_BITS-1:0] count_eff;
   logic [COUNT_BITS-1:0] counter_next;
   fused_type             best_cost_pick;
   logic [DISP_BITS-1:0]  best_disp_pick;
   logic [DISP_BITS+SCALE_BITS-1:0] scaled;

   logic [DISP_BITS-1:0]  counter_ff,   counter_in;
   fused_type             best_cost_ff, best_cost_in;
   logic [DISP_BITS-1:0]  best_disp_ff, best_disp_in;
   logic                  valid_ff,     valid_in;
   fused_type             fused_ff;
   logic [DISP_BITS-1:0]  disp_ff,      disp_in;
   logic                  last_ff;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      better         = fused < best_cost_ff;
      best_cost_pick = better ? fused : best_cost_ff;
      best_disp_pick = better ? counter_ff : best_disp_ff;

      if (cfg.max_disparity < MAX_DISP_LOW) begin
         count_eff = MAX_DISP_LOW;
      end else if (cfg.max_disparity > MAX_DISP_HIGH) begin
         count_eff = MAX_DISP_HIGH;
      end else begin
         count_eff = cfg.max_disparity;
      end
      counter_next = COUNT_BITS'(counter_ff) + COUNT_BITS'(1);
      last         = counter_next >= count_eff;

      scaled  = (DISP_BITS+SCALE_BITS)'(best_disp_pick) *
                (DISP_BITS+SCALE_BITS)'(cfg.disparity_scale);
      disp_in = last ? scaled[DISP_BITS-1:0] : '0;

      counter_in   = counter_ff;
      best_cost_in = best_cost_ff;
      best_disp_in = best_disp_ff;
      if (take) begin
         if (last) begin
            // rearm for the next pixel
            counter_in   = FIRST_DISPARITY;
            best_cost_in = '1;
            best_disp_in = '0;
         end else begin
            counter_in   = counter_next[DISP_BITS-1:0];
            best_cost_in = best_cost_pick;
            best_disp_in = best_disp_pick;
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= FIRST_DISPARITY;
         best_cost_ff <= '1;
         best_disp_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         best_cost_ff <= best_cost_in;
         best_disp_ff <= best_disp_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         fused_ff <= fused;
         disp_ff  <= disp_in;
         last_ff  <= last;
      end
   end

   assign out_valid     = valid_ff;
   assign out_fused     = fused_ff;
   assign out_disparity = disp_ff;
   assign out_last      = last_ff;

endmodule
